@@ rtl/core/gna_pkg.sv @@
// Package for the greedy nearest assignment unit: op codes and shared types.
// No dependencies.
`default_nettype none
package gna_pkg;
  localparam logic [1:0] OpLoadAgent = 2'd0;
  localparam logic [1:0] OpLoadTask  = 2'd1;
  localparam logic [1:0] OpRun       = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store the captured item (agent or task)
    logic scan_init;  // start a scan pass, clear the best tracker of the current phase
    logic scan_step;  // evaluate the entry under the scan pointer
    logic commit;     // mark the chosen task done and agent taken
    logic clear;      // empty both stores
  } gna_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_end;   // scan pointer is at the last slot
    logic have_task;  // an open task was found
    logic have_agent; // a free agent was found
  } gna_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/gna_datapath.sv @@
// Datapath: agent and task stores, scan pointer, distance unit, best trackers.
// Depends on gna_pkg.
`default_nettype none
module gna_datapath #(
  parameter int MaxAgents = 16,
  parameter int MaxTasks  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [1:0]          op_i,
  input  wire logic [31:0]         id_i,
  input  wire logic [47:0]         xyz_i,
  input  wire gna_pkg::gna_cmd_t   cmd_i,
  input  wire logic                phase_i, // 0 task search, 1 agent search
  output gna_pkg::gna_sts_t        sts_o,
  output logic [31:0]              agent_id_o,
  output logic [31:0]              task_id_o
);
  import gna_pkg::*;
  localparam int AW = (MaxAgents > 1) ? $clog2(MaxAgents) : 1;
  localparam int TW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int SN = (MaxAgents > MaxTasks) ? MaxAgents : MaxTasks;
  localparam int SW = (SN > 1) ? $clog2(SN) : 1;

  logic [31:0] a_id_q [MaxAgents];
  logic [47:0] a_xyz_q [MaxAgents];
  logic [31:0] t_id_q [MaxTasks];
  logic [47:0] t_xyz_q [MaxTasks];
  logic [MaxAgents-1:0] a_free_q;
  logic [MaxTasks-1:0]  t_done_q;
  logic [AW:0] a_cnt_q;
  logic [TW:0] t_cnt_q;
  logic [SW-1:0] ptr_q;

  logic have_t_q, have_a_q;
  logic [TW-1:0] best_t_q;
  logic [AW-1:0] best_a_q;
  logic [49:0] best_d_q;

  // id match search for loads
  logic a_hit, t_hit;
  logic [AW-1:0] a_hit_idx;
  logic [TW-1:0] t_hit_idx;
  always_comb begin
    a_hit = 1'b0; a_hit_idx = '0;
    for (int i = 0; i < MaxAgents; i++)
      if (!a_hit && (i < a_cnt_q) && a_id_q[i] == id_i) begin
        a_hit = 1'b1; a_hit_idx = AW'(i);
      end
    t_hit = 1'b0; t_hit_idx = '0;
    for (int i = 0; i < MaxTasks; i++)
      if (!t_hit && (i < t_cnt_q) && t_id_q[i] == id_i) begin
        t_hit = 1'b1; t_hit_idx = TW'(i);
      end
  end

  // distance of agent under the pointer to the chosen task
  logic [AW-1:0] pa;
  logic [TW-1:0] pt;
  assign pa = AW'(ptr_q);
  assign pt = TW'(ptr_q);
  logic signed [16:0] dx, dy, dz;
  logic [33:0] sq_x, sq_y, sq_z;
  logic [33:0] sq;
  logic [49:0] dist_sq;
  assign dx = $signed({a_xyz_q[pa][15], a_xyz_q[pa][15:0]})
            - $signed({t_xyz_q[best_t_q][15], t_xyz_q[best_t_q][15:0]});
  assign dy = $signed({a_xyz_q[pa][31], a_xyz_q[pa][31:16]})
            - $signed({t_xyz_q[best_t_q][31], t_xyz_q[best_t_q][31:16]});
  assign dz = $signed({a_xyz_q[pa][47], a_xyz_q[pa][47:32]})
            - $signed({t_xyz_q[best_t_q][47], t_xyz_q[best_t_q][47:32]});
  assign sq_x = dx * dx;
  assign sq_y = dy * dy;
  assign sq_z = dz * dz;
  assign sq = sq_x + sq_y + sq_z;
  assign dist_sq = 50'(sq);

  logic a_ok, t_ok, a_better;
  assign a_ok = (32'(ptr_q) < 32'(a_cnt_q)) && (32'(ptr_q) < MaxAgents) && a_free_q[pa];
  assign t_ok = (32'(ptr_q) < 32'(t_cnt_q)) && (32'(ptr_q) < MaxTasks) && !t_done_q[pt];
  assign a_better = !have_a_q || dist_sq < best_d_q ||
    (dist_sq == best_d_q && $signed(a_id_q[pa]) > $signed(a_id_q[best_a_q]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_free_q <= '0; t_done_q <= '0; a_cnt_q <= '0; t_cnt_q <= '0;
      ptr_q <= '0; have_t_q <= 1'b0; have_a_q <= 1'b0;
    end else begin
      if (cmd_i.load && op_i == OpLoadAgent) begin
        if (a_hit) a_xyz_q[a_hit_idx] <= xyz_i;
        else if (32'(a_cnt_q) < MaxAgents) begin
          a_id_q[AW'(a_cnt_q)] <= id_i;
          a_xyz_q[AW'(a_cnt_q)] <= xyz_i;
          a_free_q[AW'(a_cnt_q)] <= 1'b1;
          a_cnt_q <= a_cnt_q + 1'b1;
        end
      end
      if (cmd_i.load && op_i == OpLoadTask) begin
        if (t_hit) t_xyz_q[t_hit_idx] <= xyz_i;
        else if (32'(t_cnt_q) < MaxTasks) begin
          t_id_q[TW'(t_cnt_q)] <= id_i;
          t_xyz_q[TW'(t_cnt_q)] <= xyz_i;
          t_cnt_q <= t_cnt_q + 1'b1;
        end
      end
      if (cmd_i.scan_init) begin
        ptr_q <= '0;
        if (phase_i) have_a_q <= 1'b0;
        else have_t_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        ptr_q <= ptr_q + 1'b1;
        if (!phase_i && t_ok && (!have_t_q || t_id_q[pt] < t_id_q[best_t_q])) begin
          have_t_q <= 1'b1; best_t_q <= pt;
        end
        if (phase_i && a_ok && a_better) begin
          have_a_q <= 1'b1; best_a_q <= pa; best_d_q <= dist_sq;
        end
      end
      if (cmd_i.commit) begin
        t_done_q[best_t_q] <= 1'b1;
        if (have_a_q) begin
          a_free_q[best_a_q] <= 1'b0;
        end
      end
      if (cmd_i.clear) begin
        a_free_q <= '0; t_done_q <= '0; a_cnt_q <= '0; t_cnt_q <= '0;
        have_t_q <= 1'b0; have_a_q <= 1'b0;
      end
    end
  end

  assign sts_o.scan_end   = (32'(ptr_q) == SN - 1);
  assign sts_o.have_task  = have_t_q;
  assign sts_o.have_agent = have_a_q;
  assign agent_id_o = a_id_q[best_a_q];
  assign task_id_o  = t_id_q[best_t_q];
endmodule
`default_nettype wire

@@ rtl/core/gna_ctrl.sv @@
// Controller state machine sequencing loads, scan passes and result transfers.
// Depends on gna_pkg.
`default_nettype none
module gna_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_fire_i,
  input  wire logic [1:0]        op_i,
  input  wire logic              out_ready_i,
  input  wire gna_pkg::gna_sts_t sts_i,
  output gna_pkg::gna_cmd_t      cmd_o,
  output logic                   phase_o,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output logic                   out_pair_o,
  output logic                   out_last_o
);
  import gna_pkg::*;
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StTscan = 3'd1;
  localparam logic [2:0] StAinit = 3'd2;
  localparam logic [2:0] StAscan = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;
  localparam logic [2:0] StFinal = 3'd5;

  logic [2:0] state_q, state_d;
  // rounds: bounded by task slots, one task done per pass
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    phase_o = (state_q == StAinit) || (state_q == StAscan);
    in_ready_o = (state_q == StIdle);
    out_valid_o = 1'b0; out_pair_o = 1'b0; out_last_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_fire_i) begin
          if (op_i == OpRun) begin
            cmd_o.scan_init = 1'b1; state_d = StTscan;
          end else cmd_o.load = 1'b1;
        end
      end
      StTscan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_end) state_d = StAinit;
      end
      StAinit: begin
        if (!sts_i.have_task) state_d = StFinal;
        else begin
          cmd_o.scan_init = 1'b1; state_d = StAscan;
        end
      end
      StAscan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_end) state_d = StEmit;
      end
      StEmit: begin
        if (!sts_i.have_agent) begin
          cmd_o.commit = 1'b1; cmd_o.scan_init = 1'b1; state_d = StTscan;
        end else begin
          out_valid_o = 1'b1; out_pair_o = 1'b1;
          if (out_ready_i) begin
            cmd_o.commit = 1'b1; cmd_o.scan_init = 1'b1; state_d = StTscan;
          end
        end
      end
      StFinal: begin
        // last marker rides on the held pair when pairs came earlier, else on an empty transfer
        out_valid_o = 1'b1; out_last_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.clear = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

@@ rtl/core/greedy_nearest_assignment_unit.sv @@
// Greedy nearest assignment unit: top level joining controller and datapath.
// Depends on gna_pkg, gna_ctrl, gna_datapath.
`default_nettype none
// Load items (agent or task) are taken back to back while idle. A run item
// walks the task store to find the lowest open id, then the agent store to
// find the nearest free agent, one slot per cycle through a single distance
// unit; a run takes MAX_TASKS rounds at most plus a closing task scan. No
// input is taken during a run. Pairs leave in task order. Because the final
// pair is only known after the next round, the result buffer holds each
// pair until the next pair or the end of the run and marks last on the pair
// that closes the run; a run without pairs gives one transfer with
// valid_res clear.
module greedy_nearest_assignment_unit #(
  parameter int MAX_AGENTS = 16,
  parameter int MAX_TASKS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: agent_id[31:0], task_id[63:32], pos_x[79:64], pos_y[95:80], pos_z[111:96]
  input  wire logic [111:0] s_axis_tdata,
  // tuser: op[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: out_agent_id[31:0], out_task_id[63:32]
  output logic [63:0]      m_axis_tdata,
  // tuser: valid_res[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);
  import gna_pkg::*;
  gna_cmd_t cmd;
  gna_sts_t sts;
  logic phase, in_ready, c_valid, c_pair, c_last;
  logic [31:0] aid, tid;
  logic in_fire;

  // one-deep hold buffer so each pair learns whether it is the last
  logic hold_q;
  logic [63:0] hold_data_q;
  logic c_ready;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = in_ready;

  gna_datapath #(.MaxAgents(MAX_AGENTS), .MaxTasks(MAX_TASKS)) u_dp (
    .clk_i, .rst_ni, .op_i(s_axis_tuser),
    .id_i(s_axis_tuser == OpLoadTask ? s_axis_tdata[63:32] : s_axis_tdata[31:0]),
    .xyz_i(s_axis_tdata[111:64]), .cmd_i(cmd), .phase_i(phase),
    .sts_o(sts), .agent_id_o(aid), .task_id_o(tid)
  );

  gna_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .op_i(s_axis_tuser),
    .out_ready_i(c_ready), .sts_i(sts), .cmd_o(cmd), .phase_o(phase),
    .in_ready_o(in_ready), .out_valid_o(c_valid), .out_pair_o(c_pair),
    .out_last_o(c_last)
  );

  // pair: taken into hold when hold is empty or hold drains now
  // final: with hold full, emit hold as last; with hold empty, emit empty result
  always_comb begin
    m_axis_tvalid = 1'b0; m_axis_tlast = 1'b0; m_axis_tuser = 1'b0;
    m_axis_tdata = '0; c_ready = 1'b0;
    if (c_valid && c_pair) begin
      m_axis_tvalid = hold_q;
      m_axis_tuser = 1'b1;
      m_axis_tdata = hold_data_q;
      c_ready = !hold_q || m_axis_tready;
    end else if (c_valid && c_last) begin
      m_axis_tvalid = 1'b1; m_axis_tlast = 1'b1;
      m_axis_tuser = hold_q;
      m_axis_tdata = hold_q ? hold_data_q : '0;
      c_ready = m_axis_tready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_q <= 1'b0;
    else if (c_valid && c_pair && c_ready) hold_q <= 1'b1;
    else if (c_valid && c_last && c_ready) hold_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (c_valid && c_pair && c_ready) hold_data_q <= {tid, aid};
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during run");
  a_last_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && !m_axis_tuser) |-> !hold_q)
    else $error("empty result with pending pair");
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped");
`endif
endmodule
`default_nettype wire
